@@ hdl/lsa_pkg.sv @@
package lsa_pkg;
  localparam int MaxValues  = 1024;
  localparam int MaxNodes   = 1024;
  localparam int MaxSlots   = 64;
  localparam int BytesWidth = 32;
  localparam int VidW  = 10;
  localparam int NodeW = 10;
  localparam int EndW  = 11;
  localparam int SlotW = 6;
  localparam int CntW  = 7;
  localparam int AlignW = 13;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 11;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    OpDeclare = 2'd0,
    OpUse     = 2'd1,
    OpPlan    = 2'd2,
    OpRead    = 2'd3
  } op_e;

  localparam logic [CfgIdxW-1:0] RegNodeCount   = 1'd0;
  localparam logic [CfgIdxW-1:0] RegPreserveAll = 1'd1;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [VidW-1:0]       val_idx;
    logic [NodeW-1:0]      node_index;
    logic                  arena_candidate;
    logic [BytesWidth-1:0] byte_count;
    logic [AlignW-1:0]     align_bytes;
    logic                  is_exposed;
    logic [SlotW-1:0]      slot_select;
  } in_item_t;

  typedef struct packed {
    logic                  slot_valid;
    logic [SlotW-1:0]      slot_index;
    logic [NodeW-1:0]      live_start;
    logic [EndW-1:0]       live_end;
    logic [BytesWidth-1:0] slot_bytes;
    logic [AlignW-1:0]     slot_align;
    logic [CntW-1:0]       slots_used;
    logic                  status;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    op_e                   op;
    logic                  do_alloc;
    logic [VidW-1:0]       val_idx;
    logic [NodeW-1:0]      node_index;
    logic                  force_end;
    logic [BytesWidth-1:0] byte_count;
    logic [AlignW-1:0]     align_bytes;
    logic [SlotW-1:0]      slot_select;
  } cmd_t;
endpackage

@@ hdl/lsa_if.sv @@
interface lsa_in_if import lsa_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lsa_out_if import lsa_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/lsa_front.sv @@
module lsa_front import lsa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsa_in_if.sink     in_ch,
  input  logic       preserve_all_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_pop_i
);
  cmd_t             q_mem [QDepth];
  logic [0:0]       wr_q, rd_q;
  logic [1:0]       cnt_q;
  cmd_t             c;
  logic             push;

  always_comb begin
    c.op          = op_e'(in_ch.data.opcode);
    c.do_alloc    = in_ch.data.arena_candidate && (in_ch.data.byte_count != '0);
    c.val_idx     = in_ch.data.val_idx;
    c.node_index  = in_ch.data.node_index;
    c.force_end   = in_ch.data.is_exposed || preserve_all_i;
    c.byte_count  = in_ch.data.byte_count;
    c.align_bytes = (in_ch.data.align_bytes == '0) ? AlignW'(1) : in_ch.data.align_bytes;
    c.slot_select = in_ch.data.slot_select;
  end

  assign in_ch.ready = (cnt_q != 2'(QDepth));
  assign push = in_ch.valid && in_ch.ready;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o = q_mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (cmd_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end
endmodule

@@ hdl/lsa_back.sv @@
module lsa_back import lsa_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  cmd_t          cmd_i,
  output logic          cmd_pop_o,
  input  logic [EndW-1:0] node_count_i,
  lsa_out_if.source     out_ch
);
  typedef enum logic [2:0] {
    StIdle, StLook, StScan, StSlot, StFin, StOut
  } state_e;

  logic [NodeW-1:0]      prod_mem [MaxValues];
  logic [NodeW-1:0]      last_mem [MaxValues];
  logic [EndW-1:0]       end_mem  [MaxSlots];
  logic [BytesWidth-1:0] bytes_mem [MaxSlots];
  logic [AlignW-1:0]     align_mem [MaxSlots];

  state_e                st_q;
  cmd_t                  cmd_q;
  logic [NodeW-1:0]      prod_q, last_q;
  logic [EndW-1:0]       rd_end_q;
  logic [BytesWidth-1:0] rd_bytes_q;
  logic [AlignW-1:0]     rd_align_q;
  logic [CntW-1:0]       cnt_q, k_q;
  logic [SlotW-1:0]      slot_q;
  logic                  fresh_q;
  out_item_t             out_q;
  logic                  out_v_q;
  logic [SlotW-1:0]      rd_addr;
  logic [EndW-1:0]       end_val;
  logic [BytesWidth-1:0] nb;
  logic [AlignW-1:0]     na;
  out_item_t             look_res;

  assign out_ch.valid = out_v_q;
  assign out_ch.data  = out_q;
  assign cmd_pop_o = (st_q == StIdle) && cmd_valid_i && !out_v_q;
  assign end_val = cmd_q.force_end ? node_count_i : EndW'(last_q);

  always_comb begin
    rd_addr = k_q[SlotW-1:0];
    if (st_q == StIdle) rd_addr = cmd_i.slot_select;
    else if (st_q == StSlot) rd_addr = slot_q;
  end

  always_comb begin
    nb = fresh_q ? '0 : rd_bytes_q;
    na = fresh_q ? AlignW'(1) : rd_align_q;
    if (cmd_q.byte_count > nb) nb = cmd_q.byte_count;
    if (cmd_q.align_bytes > na) na = cmd_q.align_bytes;
  end

  // result of declare, use, read and of a plan before the slot search
  always_comb begin
    look_res = '0;
    look_res.slot_align = AlignW'(1);
    look_res.slots_used = cnt_q;
    unique case (cmd_q.op)
      OpPlan: begin
        look_res.live_start = prod_q;
        look_res.live_end = end_val;
      end
      OpRead: begin
        look_res.slot_index = cmd_q.slot_select;
        if (CntW'(cmd_q.slot_select) < cnt_q) begin
          look_res.slot_valid = 1'b1;
          look_res.slot_bytes = rd_bytes_q;
          look_res.slot_align = rd_align_q;
        end
      end
      default: begin
      end
    endcase
  end

  // slot memories, registered read
  always_ff @(posedge clk_i) begin
    rd_end_q   <= end_mem[rd_addr];
    rd_bytes_q <= bytes_mem[rd_addr];
    rd_align_q <= align_mem[rd_addr];
    if (st_q == StFin) begin
      end_mem[slot_q]   <= end_val;
      bytes_mem[slot_q] <= nb;
      align_mem[slot_q] <= na;
    end
  end

  // value memories; the entries read at pop stay put for the whole item
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      prod_q <= prod_mem[cmd_i.val_idx];
      last_q <= last_mem[cmd_i.val_idx];
    end
    if (st_q == StLook && cmd_q.op == OpDeclare) begin
      prod_mem[cmd_q.val_idx] <= cmd_q.node_index;
      last_mem[cmd_q.val_idx] <= cmd_q.node_index;
    end else if (st_q == StLook && cmd_q.op == OpUse && last_q < cmd_q.node_index) begin
      last_mem[cmd_q.val_idx] <= cmd_q.node_index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; k_q <= '0; out_v_q <= 1'b0;
      slot_q <= '0; fresh_q <= 1'b0; cmd_q <= '0; out_q <= '0;
    end else begin
      if (out_v_q && out_ch.ready) out_v_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (cmd_pop_o) begin
            cmd_q <= cmd_i;
            st_q <= StLook;
          end
        end
        StLook: begin
          out_q <= look_res;
          k_q <= '0;
          if (cmd_q.op == OpPlan && cmd_q.do_alloc) st_q <= StScan;
          else st_q <= StOut;
        end
        StScan: begin
          // one slot end per cycle; rd_end_q holds entry k_q-1
          if (k_q != '0 && rd_end_q < EndW'(prod_q)) begin
            slot_q <= SlotW'(k_q - 1'b1); fresh_q <= 1'b0; st_q <= StSlot;
          end else if (k_q >= cnt_q) begin
            if (cnt_q == CntW'(MaxSlots)) begin
              out_q.status <= 1'b1; st_q <= StOut;
            end else begin
              slot_q <= cnt_q[SlotW-1:0]; fresh_q <= 1'b1;
              cnt_q <= cnt_q + 1'b1; st_q <= StSlot;
            end
          end else k_q <= k_q + 1'b1;
        end
        StSlot: st_q <= StFin;
        StFin: begin
          out_q.slot_valid <= 1'b1;
          out_q.slot_index <= slot_q;
          out_q.slot_bytes <= nb;
          out_q.slot_align <= na;
          out_q.slots_used <= cnt_q;
          st_q <= StOut;
        end
        StOut: begin
          if (!out_v_q) begin
            out_v_q <= 1'b1; st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule

@@ hdl/liveness_slot_allocator_unit.sv @@
// liveness slot allocator
// in_ch carries declare, use, plan and read-slot items; out_ch returns one
// result item per input item, in order. both are valid/ready channels.
// configuration: cfg_we_i writes cfg_idx_i (0 node_count, 1 preserve_all)
// with cfg_data_i. the user must write only while the block is idle; the
// block does not enforce it. the front classifies items into a two-entry
// queue; the back executes them. declare, use and read pass through the
// look and output states. a plan scans slot ends one per cycle from the
// slot memory, with up to 64 slots open. one item is executed at a time.
// the result waits in an output register while the front keeps accepting
// up to two more items; when out_ch stalls the back holds and then the queue
// fills and in_ch drops ready.
// reset clears the slot count and registers; value and slot stores are
// undefined until written and need no clearing pass.
module liveness_slot_allocator_unit import lsa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  lsa_in_if.sink              in_ch,
  lsa_out_if.source           out_ch,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  logic [EndW-1:0] node_count_q;
  logic            preserve_all_q;
  logic            cmd_valid, cmd_pop;
  cmd_t            cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= '0; preserve_all_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegNodeCount) node_count_q <= cfg_data_i;
      else if (cfg_idx_i == RegPreserveAll) preserve_all_q <= cfg_data_i[0];
    end
  end

  lsa_front u_front (
    .clk_i, .rst_ni, .in_ch, .preserve_all_i(preserve_all_q),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  lsa_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .node_count_i(node_count_q), .out_ch
  );
endmodule

@@ bench/lsa_result_checker.sv @@
`timescale 1ns / 1ps

module lsa_result_checker import lsa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  lsa_in_if                   in_mon,
  lsa_out_if                  out_mon,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count,
  output int                  pending
);

  logic [NodeW-1:0]  producer_node [MaxValues];
  logic [NodeW-1:0]  last_use_node [MaxValues];
  logic [EndW-1:0]   slot_end      [MaxSlots];
  logic [31:0]       slot_size     [MaxSlots];
  logic [AlignW-1:0] slot_align_max[MaxSlots];
  int                open_slots;
  logic [EndW-1:0]   graph_end;
  logic              keep_all;
  out_item_t         expected_results[$];

  function automatic out_item_t plan_outcome(in_item_t it);
    out_item_t r;
    logic [AlignW-1:0] need_align;
    logic [EndW-1:0]   stop;
    int slot;
    r = '0;
    r.slot_align = AlignW'(1);
    need_align = (it.align_bytes == 0) ? AlignW'(1) : it.align_bytes;
    case (op_e'(it.opcode))
      OpDeclare: begin
        producer_node[it.val_idx] = it.node_index;
        last_use_node[it.val_idx] = it.node_index;
      end
      OpUse: begin
        if (last_use_node[it.val_idx] < it.node_index)
          last_use_node[it.val_idx] = it.node_index;
      end
      OpPlan: begin
        stop = (it.is_exposed || keep_all) ? graph_end : EndW'(last_use_node[it.val_idx]);
        r.live_start = producer_node[it.val_idx];
        r.live_end = stop;
        if (it.arena_candidate && it.byte_count != 0) begin
          slot = -1;
          for (int k = 0; k < open_slots; k++) begin
            if (slot < 0 && slot_end[k] < EndW'(producer_node[it.val_idx])) slot = k;
          end
          if (slot < 0 && open_slots < MaxSlots) begin
            slot = open_slots;
            slot_size[slot] = '0;
            slot_align_max[slot] = AlignW'(1);
            open_slots++;
          end
          if (slot >= 0) begin
            slot_end[slot] = stop;
            if (it.byte_count > slot_size[slot]) slot_size[slot] = it.byte_count;
            if (need_align > slot_align_max[slot]) slot_align_max[slot] = need_align;
            r.slot_valid = 1'b1;
            r.slot_index = SlotW'(slot);
            r.slot_bytes = slot_size[slot];
            r.slot_align = slot_align_max[slot];
          end else begin
            r.status = 1'b1;
          end
        end
      end
      default: begin
        r.slot_index = it.slot_select;
        if (it.slot_select < open_slots) begin
          r.slot_valid = 1'b1;
          r.slot_bytes = slot_size[it.slot_select];
          r.slot_align = slot_align_max[it.slot_select];
        end
      end
    endcase
    r.slots_used = CntW'(open_slots);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      open_slots <= 0;
      graph_end <= '0;
      keep_all <= 1'b0;
      fail_count <= 0;
      pending <= 0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegNodeCount) graph_end <= EndW'(cfg_data_i);
        else if (cfg_idx_i == RegPreserveAll) keep_all <= cfg_data_i[0];
      end
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result item %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.slot_valid !== want.slot_valid || got.slot_index !== want.slot_index ||
              got.live_start !== want.live_start || got.live_end !== want.live_end ||
              got.slot_bytes !== want.slot_bytes || got.slot_align !== want.slot_align ||
              got.slots_used !== want.slots_used || got.status !== want.status) begin
            if (fail_count < 10) $display("mismatch: expected %p got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      // predict after the pop so a same-cycle push never gets compared early
      if (in_mon.valid && in_mon.ready) expected_results.push_back(plan_outcome(in_mon.data));
      pending <= expected_results.size();
    end
  end

endmodule

@@ bench/liveness_slot_allocator_unit_test.sv @@
`timescale 1ns / 1ps

module liveness_slot_allocator_unit_test;
  import lsa_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int                  fail_count;
  int                  pending;
  int                  cycle_count = 0;
  bit                  quiet = 1'b0;
  bit                  hold_req = 1'b0;
  bit                  declared[MaxValues];
  int                  sent = 0;

  lsa_in_if  in_ch ();
  lsa_out_if out_ch ();

  liveness_slot_allocator_unit DUT (
    .clk_i, .rst_ni, .in_ch, .out_ch, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  lsa_result_checker checker_i (
    .clk_i, .rst_ni, .in_mon(in_ch), .out_mon(out_ch), .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .fail_count, .pending
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        for (int c = 0; c < 400; c++) @(posedge clk_i);
      end
      stall = quiet ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  function automatic in_item_t noise_item();
    in_item_t it;
    it.opcode = 2'($urandom_range(0, 3));
    it.val_idx = VidW'($urandom_range(0, MaxValues - 1));
    it.node_index = NodeW'($urandom_range(0, MaxNodes - 1));
    it.arena_candidate = 1'($urandom_range(0, 1));
    it.byte_count = $urandom();
    it.align_bytes = AlignW'($urandom_range(0, 4096));
    it.is_exposed = 1'($urandom_range(0, 1));
    it.slot_select = SlotW'($urandom_range(0, 63));
    return it;
  endfunction

  task automatic send(input in_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    if (op_e'(it.opcode) == OpDeclare) declared[it.val_idx] = 1'b1;
    sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_config(input int nodes, input bit keep);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= RegNodeCount;
    cfg_data_i <= CfgDataW'(nodes);
    @(posedge clk_i);
    cfg_idx_i <= RegPreserveAll;
    cfg_data_i <= CfgDataW'(keep);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic op_item(input op_e op, input int vid, input int node, input bit cand,
                         input logic [31:0] bytes, input int align, input bit exposed);
    in_item_t it;
    it = noise_item();
    it.opcode = op;
    it.val_idx = VidW'(vid);
    it.node_index = NodeW'(node);
    it.arena_candidate = cand;
    it.byte_count = bytes;
    it.align_bytes = AlignW'(align);
    it.is_exposed = exposed;
    send(it);
  endtask

  task automatic read_slot(input int sel);
    in_item_t it;
    it = noise_item();
    it.opcode = OpRead;
    it.slot_select = SlotW'(sel);
    send(it);
  endtask

  // a value's life: declare, some uses, then plan; else a slot read or a noisy item
  task automatic random_episode();
    int pick, vid, node, uses;
    logic [31:0] bytes;
    in_item_t it;
    pick = $urandom_range(0, 99);
    vid = $urandom_range(0, MaxValues - 1);
    if (pick < 60) begin
      node = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MaxNodes - 1)
                                         : $urandom_range(0, 255);
      op_item(OpDeclare, vid, node, 1'($urandom_range(0, 1)), $urandom(),
              $urandom_range(0, 4096), 1'($urandom_range(0, 1)));
      uses = $urandom_range(0, 3);
      for (int u = 0; u < uses; u++)
        op_item(OpUse, vid, $urandom_range(node, (node + 80 > 1023) ? 1023 : node + 80),
                1'($urandom_range(0, 1)), $urandom(), $urandom_range(0, 4096),
                1'($urandom_range(0, 1)));
      bytes = ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 4096);
      if ($urandom_range(0, 19) == 0) bytes = 0;
      op_item(OpPlan, vid, $urandom_range(0, 1023), $urandom_range(0, 9) != 0, bytes,
              $urandom_range(0, 4096), $urandom_range(0, 9) == 0);
    end else if (pick < 75) begin
      read_slot($urandom_range(0, 63));
    end else begin
      it = noise_item();
      if (op_e'(it.opcode) != OpDeclare && op_e'(it.opcode) != OpRead && !declared[vid])
        it.opcode = OpDeclare;
      it.val_idx = VidW'(vid);
      send(it);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_config(1024, 1'b0);

    op_item(OpDeclare, 0, 0, 1, 32'hFFFF_FFFF, 4096, 1);
    op_item(OpUse, 0, 1023, 0, 0, 0, 0);
    op_item(OpUse, 0, 5, 1, 1, 1, 1);
    op_item(OpPlan, 0, 0, 1, 32'hFFFF_FFFF, 4096, 0);
    op_item(OpDeclare, 1, 1023, 0, 0, 0, 0);
    op_item(OpPlan, 1, 1023, 1, 1, 0, 0);
    op_item(OpDeclare, 2, 0, 1, 7, 8, 0);
    op_item(OpPlan, 2, 0, 0, 7, 8, 0);
    op_item(OpDeclare, 3, 5, 1, 7, 8, 0);
    op_item(OpPlan, 3, 5, 1, 0, 8, 0);
    op_item(OpDeclare, 1023, 1023, 1, 9, 16, 1);
    op_item(OpPlan, 1023, 0, 1, 9, 16, 1);
    op_item(OpDeclare, 4, 1, 1, 9, 16, 1);
    op_item(OpPlan, 4, 0, 1, 32'h8000_0000, 4095, 0);
    read_slot(0);
    read_slot(1);
    read_slot(63);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_config(0, 1'b1);
        1: write_config(1023, 1'b0);
        2: write_config(1024, 1'b1);
        default: write_config($urandom_range(0, 1024), 1'($urandom_range(0, 1)));
      endcase
      quiet = (phase == 1);
      for (int n = 0; n < 175; n++) begin
        if (phase == 2 && n == 100) hold_req = 1'b1;
        if (phase == 3 && n == 80) drain();
        random_episode();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/lsa_pkg.sv
hdl/lsa_if.sv
hdl/lsa_front.sv
hdl/lsa_back.sv
hdl/liveness_slot_allocator_unit.sv
bench/lsa_result_checker.sv
bench/liveness_slot_allocator_unit_test.sv
